### hw/rtl/frns_pkg.sv
// ----------------------------------------------------------------------------
// frns_pkg
// Shared types, character codes and keyword tables of the routine name spotter.
// ----------------------------------------------------------------------------
package frns_pkg;

    localparam int NKW     = 11;
    localparam int KW_BITS = 80;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam int KW_DOUBLE    = 2;
    localparam int KW_PRECISION = 3;
    localparam int KW_ROUTINE   = 7;

    localparam logic [NKW-1:0] MASK_FIRST     = 11'h7F7;
    localparam logic [NKW-1:0] MASK_KW        = 11'h780;
    localparam logic [NKW-1:0] MASK_PRECISION = 11'h008;

    localparam logic [KW_BITS-1:0] KW_TEXT [NKW] = '{
        "complex", "character", "double", "precision", "integer", "logical",
        "real", "function", "program", "procedure", "subroutine"
    };

    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd7, 4'd9, 4'd6, 4'd9, 4'd7, 4'd7, 4'd4, 4'd8, 4'd7, 4'd9, 4'd10
    };

    typedef enum logic [3:0] {
        PH_START,
        PH_SKIP1,
        PH_MATCH,
        PH_PREC_SKIP,
        PH_STAR,
        PH_STAR_SP,
        PH_DIGITS,
        PH_DBL_SKIP,
        PH_SKIP2,
        PH_SKIP3,
        PH_NAME,
        PH_DEAD
    } phase_t;

    typedef enum logic {
        ST_SCAN,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic advance;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic emit_req;
        logic last_char;
    } dp_status_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        is_name_char = is_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_Z))
                    || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
        logic [KW_BITS-1:0] w;
        int                 l;
        w = KW_TEXT[k];
        l = int'(KW_LEN[k]);
        kw_char = CH_NUL;
        if (int'(p) < l)
        begin
            kw_char = w[(l - 1 - int'(p)) * 8 +: 8];
        end
    endfunction

    function automatic logic [NKW-1:0] kw_first(input logic [7:0] f,
                                                input logic [NKW-1:0] mask);
        kw_first = '0;
        for (int k = 0; k < NKW; k++)
        begin
            kw_first[k] = mask[k] && (kw_char(k, 4'd0) == f);
        end
    endfunction

    function automatic logic [NKW-1:0] kw_next(input logic [NKW-1:0] cand,
                                               input logic [3:0] pos,
                                               input logic [7:0] f);
        kw_next = '0;
        for (int k = 0; k < NKW; k++)
        begin
            kw_next[k] = cand[k] && (pos < KW_LEN[k]) && (kw_char(k, pos) == f);
        end
    endfunction

endpackage

### hw/rtl/frns_ctrl.sv
// ----------------------------------------------------------------------------
// frns_ctrl
// Handshake controller: scan input words, then read a found name out.
// ----------------------------------------------------------------------------
module frns_ctrl
    import frns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        in_fire;
    logic        out_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SCAN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready    = (state_reg == ST_SCAN);
        out_valid   = (state_reg == ST_EMIT);
        in_fire     = in_valid && in_ready;
        out_fire    = out_valid && out_ready;
        cmd.accept  = in_fire;
        cmd.advance = out_fire && !status.last_char;
        cmd.finish  = out_fire && status.last_char;
        state_next  = state_reg;
        unique case (state_reg)
            ST_SCAN:
            begin
                if (in_fire && status.emit_req)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.finish)
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
    end

endmodule

### hw/rtl/frns_dp.sv
// ----------------------------------------------------------------------------
// frns_dp
// Datapath: line scanner, keyword matcher, name buffer and name readout.
// ----------------------------------------------------------------------------
module frns_dp
    import frns_pkg::*;
#(
    parameter int MAX_NAME  = 32,
    parameter int LINE_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic [7:0]  name_char,
    output logic [23:0] line_number,
    output logic        truncated
);

    localparam int IDX_W = $clog2(MAX_NAME);
    localparam int LEN_W = $clog2(MAX_NAME + 1);

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [NKW-1:0]         cand_reg;
    logic [NKW-1:0]         cand_next;
    logic [3:0]             pos_reg;
    logic [3:0]             pos_next;
    logic [LEN_W-1:0]       name_length_reg;
    logic [LEN_W-1:0]       name_length_next;
    logic                   overflow_reg;
    logic                   overflow_next;
    logic [LINE_BITS-1:0]   line_count_reg;
    logic [LINE_BITS-1:0]   line_count_next;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [7:0]             rd_data_reg;
    logic [7:0]             name_mem [MAX_NAME];
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic                   emit;
    logic [LINE_BITS+23:0]  line_wide;

    always_comb
    begin
        phase_t         ph;
        logic           process;
        logic           do_begin;
        logic [NKW-1:0] begin_mask;
        logic [NKW-1:0] hit;
        logic [7:0]     f;
        logic           found;

        phase_next       = phase_reg;
        cand_next        = cand_reg;
        pos_next         = pos_reg;
        name_length_next = name_length_reg;
        overflow_next    = overflow_reg;
        line_count_next  = line_count_reg;
        wr_en            = 1'b0;
        wr_addr          = name_length_reg[IDX_W-1:0];
        emit             = 1'b0;
        ph               = phase_reg;
        process          = 1'b0;
        do_begin         = 1'b0;
        begin_mask       = MASK_KW;
        hit              = '0;
        found            = 1'b0;
        f                = char_code | CASE_BIT;

        if (end_of_text)
        begin
            if (phase_reg != PH_START)
            begin
                emit       = (phase_reg == PH_NAME) && (name_length_reg >= LEN_W'(2));
                phase_next = PH_START;
            end
        end
        else
        begin
            process = 1'b1;
            if (phase_reg == PH_START)
            begin
                if (line_count_reg != {LINE_BITS{1'b1}})
                begin
                    line_count_next = line_count_reg + LINE_BITS'(1);
                end
                ph         = PH_SKIP1;
                phase_next = PH_SKIP1;
                cand_next  = '0;
                pos_next   = '0;
                if (char_code == CH_PERCENT)
                begin
                    process = 1'b0;
                end
            end
        end

        if (process)
        begin
            case (ph)
                PH_SKIP1:
                begin
                    if (!is_space(char_code))
                    begin
                        do_begin   = 1'b1;
                        begin_mask = MASK_FIRST;
                    end
                end
                PH_MATCH:
                begin
                    hit      = kw_next(cand_reg, pos_reg, f);
                    pos_next = pos_reg + 4'd1;
                    if (hit == '0)
                    begin
                        phase_next = PH_DEAD;
                    end
                    else
                    begin
                        cand_next = hit;
                        for (int k = 0; k < NKW; k++)
                        begin
                            if (!found && hit[k] && (KW_LEN[k] == pos_reg + 4'd1))
                            begin
                                found     = 1'b1;
                                cand_next = '0;
                                pos_next  = '0;
                                if (k == KW_DOUBLE)
                                begin
                                    phase_next = PH_DBL_SKIP;
                                end
                                else if (k == KW_PRECISION)
                                begin
                                    phase_next = PH_SKIP2;
                                end
                                else if (k >= KW_ROUTINE)
                                begin
                                    phase_next = PH_SKIP3;
                                end
                                else
                                begin
                                    phase_next = PH_PREC_SKIP;
                                end
                            end
                        end
                    end
                end
                PH_PREC_SKIP:
                begin
                    if (char_code == CH_STAR)
                    begin
                        phase_next = PH_STAR;
                    end
                    else if (!is_space(char_code))
                    begin
                        do_begin = 1'b1;
                    end
                end
                PH_STAR:
                begin
                    if (is_space(char_code))
                    begin
                        phase_next = PH_STAR_SP;
                    end
                    else if (is_digit(char_code))
                    begin
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DEAD;
                    end
                end
                PH_STAR_SP:
                begin
                    if (is_digit(char_code))
                    begin
                        phase_next = PH_DIGITS;
                    end
                    else if (!is_space(char_code))
                    begin
                        do_begin = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_space(char_code))
                    begin
                        phase_next = PH_SKIP2;
                    end
                    else if (!is_digit(char_code))
                    begin
                        do_begin = 1'b1;
                    end
                end
                PH_DBL_SKIP:
                begin
                    if (!is_space(char_code))
                    begin
                        do_begin   = 1'b1;
                        begin_mask = MASK_PRECISION;
                    end
                end
                PH_SKIP2:
                begin
                    if (!is_space(char_code))
                    begin
                        do_begin = 1'b1;
                    end
                end
                PH_SKIP3:
                begin
                    if (char_code == CH_NUL)
                    begin
                        phase_next = PH_DEAD;
                    end
                    else if (!is_space(char_code))
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = '0;
                        name_length_next = LEN_W'(1);
                        overflow_next    = 1'b0;
                        phase_next       = PH_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (is_name_char(char_code))
                    begin
                        if (name_length_reg < LEN_W'(MAX_NAME))
                        begin
                            wr_en            = 1'b1;
                            name_length_next = name_length_reg + LEN_W'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = PH_DEAD;
                        emit       = (name_length_reg >= LEN_W'(2));
                    end
                end
                default:
                begin
                end
            endcase

            if (do_begin)
            begin
                hit = kw_first(f, begin_mask);
                if ((char_code == CH_NUL) || (hit == '0))
                begin
                    phase_next = PH_DEAD;
                end
                else
                begin
                    cand_next  = hit;
                    pos_next   = 4'd1;
                    phase_next = PH_MATCH;
                end
            end

            if (char_code == CH_NL)
            begin
                phase_next = PH_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            cand_reg        <= '0;
            pos_reg         <= '0;
            name_length_reg <= '0;
            overflow_reg    <= 1'b0;
            line_count_reg  <= '0;
            rd_idx_reg      <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                phase_reg       <= phase_next;
                cand_reg        <= cand_next;
                pos_reg         <= pos_next;
                name_length_reg <= name_length_next;
                overflow_reg    <= overflow_next;
                line_count_reg  <= line_count_next;
            end
            if (cmd.finish)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            rd_addr = '0;
        end
        else if (cmd.advance)
        begin
            rd_addr = rd_idx_reg + IDX_W'(1);
        end
        else
        begin
            rd_addr = rd_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            name_mem[wr_addr] <= char_code;
        end
        rd_data_reg <= name_mem[rd_addr];
    end

    assign line_wide        = {24'd0, line_count_reg};
    assign line_number      = line_wide[23:0];
    assign name_char        = rd_data_reg;
    assign truncated        = overflow_reg;
    assign status.emit_req  = emit;
    assign status.last_char = ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == name_length_reg);

endmodule

### hw/rtl/fortran_routine_name_spotter_top.sv
// ----------------------------------------------------------------------------
// fortran_routine_name_spotter_top
// Spot routine declarations in a text stream and stream out each name.
// Throughput: one text word per cycle while scanning.
// Latency: the first name word appears the cycle after the word that ends the
// name; the name (2 to MAX_NAME words) then streams out of the name buffer at
// one word per cycle while the output is ready; text input holds meanwhile.
// Reset clears the scanner, line count and readout control; the name buffer
// needs no clearing.
// ----------------------------------------------------------------------------
module fortran_routine_name_spotter_top
    import frns_pkg::*;
#(
    parameter int MAX_NAME  = 32,
    parameter int LINE_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tuser,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // name_char, line_number
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // truncated
);

    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [7:0]  name_char;
    logic [23:0] line_number;

    frns_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    frns_dp #(
        .MAX_NAME  (MAX_NAME),
        .LINE_BITS (LINE_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (s_axis_tdata),
        .end_of_text (s_axis_tuser),
        .cmd         (cmd),
        .status      (status),
        .name_char   (name_char),
        .line_number (line_number),
        .truncated   (m_axis_tuser)
    );

    assign m_axis_tdata = {line_number, name_char};
    assign m_axis_tlast = status.last_char;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks fortran_routine_name_spotter_top on a byte stream of source text.
// Directed lines cover the type prefixes, each routine keyword, case folding,
// the '%' lead, the star forms, one-character and over-long names, and names
// closed by zero bytes, end of text and other characters. Random lines follow,
// mostly well formed and partly broken or noise. A scanner model built into
// the bench predicts each name word. Both stream sides idle at random. The
// output side also holds off for a long stretch while text keeps coming.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import frns_pkg::*;

    localparam int NAME_MAX     = 32;
    localparam int ITEM_TARGET  = 400;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = NAME_MAX + 16;

    typedef struct packed {
        logic [7:0]  name_char;
        logic [23:0] line_number;
        logic        last;
        logic        truncated;
    } name_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    string kw_spell [NKW] = '{
        "complex", "character", "double", "precision", "integer", "logical",
        "real", "function", "program", "procedure", "subroutine"
    };
    string name_alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    name_word_t     expected_names [$];
    logic [7:0]     text_line [$];
    bit             line_eot;
    bit             src_idle;
    bit             sink_stall;
    bit             hold_request;
    int             fail_count = 0;
    int             sent_words = 0;

    phase_t         scan = PH_START;
    logic [NKW-1:0] cand = '0;
    logic [3:0]     kpos = '0;
    logic [7:0]     name_buf [NAME_MAX];
    int             name_len = 0;
    logic           name_cut = 1'b0;
    logic [23:0]    line_no = '0;

    fortran_routine_name_spotter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    function automatic bit blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic bit numeral(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic bit word_char(input logic [7:0] c);
        return numeral(c) || ((c >= CH_UP_A) && (c <= CH_UP_Z))
            || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || (c == CH_UNDER);
    endfunction

    function automatic void start_keyword(input logic [7:0] c, input logic [NKW-1:0] mask);
        logic [NKW-1:0] hit;
        int             k;
        hit = '0;
        if (c != CH_NUL)
        begin
            for (k = 0; k < NKW; k++)
            begin
                hit[k] = mask[k] && (kw_spell[k][0] == (c | CASE_BIT));
            end
        end
        if (hit == '0)
        begin
            scan = PH_DEAD;
        end
        else
        begin
            cand = hit;
            kpos = 4'd1;
            scan = PH_MATCH;
        end
    endfunction

    function automatic void keyword_finished(input int k);
        cand = '0;
        kpos = '0;
        if (k == KW_DOUBLE)
            scan = PH_DBL_SKIP;
        else if (k == KW_PRECISION)
            scan = PH_SKIP2;
        else if (k >= KW_ROUTINE)
            scan = PH_SKIP3;
        else
            scan = PH_PREC_SKIP;
    endfunction

    function automatic void emit_name();
        name_word_t w;
        int         k;
        if (name_len >= 2)
        begin
            for (k = 0; k < name_len; k++)
            begin
                w.name_char   = name_buf[k];
                w.line_number = line_no;
                w.last        = (k == name_len - 1);
                w.truncated   = name_cut;
                expected_names.push_back(w);
            end
        end
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic [NKW-1:0] hit;
        logic [7:0]     f;
        bit             done;
        int             k;
        f = c | CASE_BIT;
        case (scan)
            PH_SKIP1:
                if (!blank(c))
                    start_keyword(c, MASK_FIRST);
            PH_MATCH:
            begin
                hit = '0;
                for (k = 0; k < NKW; k++)
                begin
                    hit[k] = cand[k] && (int'(kpos) < kw_spell[k].len())
                          && (kw_spell[k][kpos] == f);
                end
                kpos = kpos + 4'd1;
                if (hit == '0)
                begin
                    scan = PH_DEAD;
                end
                else
                begin
                    cand = hit;
                    done = 1'b0;
                    for (k = 0; k < NKW; k++)
                    begin
                        if (!done && hit[k] && (kw_spell[k].len() == int'(kpos)))
                        begin
                            keyword_finished(k);
                            done = 1'b1;
                        end
                    end
                end
            end
            PH_PREC_SKIP:
                if (c == CH_STAR)
                    scan = PH_STAR;
                else if (!blank(c))
                    start_keyword(c, MASK_KW);
            PH_STAR:
                if (blank(c))
                    scan = PH_STAR_SP;
                else if (numeral(c))
                    scan = PH_DIGITS;
                else
                    scan = PH_DEAD;
            PH_STAR_SP:
                if (numeral(c))
                    scan = PH_DIGITS;
                else if (!blank(c))
                    start_keyword(c, MASK_KW);
            PH_DIGITS:
                if (blank(c))
                    scan = PH_SKIP2;
                else if (!numeral(c))
                    start_keyword(c, MASK_KW);
            PH_DBL_SKIP:
                if (!blank(c))
                    start_keyword(c, MASK_PRECISION);
            PH_SKIP2:
                if (!blank(c))
                    start_keyword(c, MASK_KW);
            PH_SKIP3:
                if (c == CH_NUL)
                begin
                    scan = PH_DEAD;
                end
                else if (!blank(c))
                begin
                    name_buf[0] = c;
                    name_len    = 1;
                    name_cut    = 1'b0;
                    scan        = PH_NAME;
                end
            PH_NAME:
                if (!word_char(c))
                begin
                    scan = PH_DEAD;
                    emit_name();
                end
                else if (name_len < NAME_MAX)
                begin
                    name_buf[name_len] = c;
                    name_len++;
                end
                else
                begin
                    name_cut = 1'b1;
                end
            default:
                ;
        endcase
    endfunction

    function automatic void predict_names(input logic [7:0] c, input logic eot);
        if (eot)
        begin
            if (scan != PH_START)
            begin
                scan_char(CH_NUL);
                scan = PH_START;
            end
            return;
        end
        if (scan == PH_START)
        begin
            if (line_no != '1)
                line_no = line_no + 24'd1;
            scan = PH_SKIP1;
            cand = '0;
            kpos = '0;
            if (c == CH_PERCENT)
                return;
        end
        scan_char(c);
        if (c == CH_NL)
        begin
            scan_char(CH_NUL);
            scan = PH_START;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic void check_field(input string what, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    task automatic send_word(input logic [7:0] c, input logic eot);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_words++;
        predict_names(c, eot);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    function automatic void add_blanks(input int n);
        logic [7:0] pool [5] = '{CH_SPACE, CH_TAB, 8'h0B, 8'h0C, CH_CR};
        repeat (n) text_line.push_back(pool[$urandom_range(0, 4)]);
    endfunction

    function automatic void add_folded(input string w);
        logic [7:0] ch;
        int         i;
        for (i = 0; i < w.len(); i++)
        begin
            ch = w[i];
            if ($urandom_range(0, 1))
                ch = ch & ~CASE_BIT;
            text_line.push_back(ch);
        end
    endfunction

    function automatic void add_name_chars(input int n);
        repeat (n) text_line.push_back(name_alphabet[$urandom_range(0, name_alphabet.len() - 1)]);
    endfunction

    function automatic void build_line();
        int pick;
        int k;
        int n;
        text_line.delete();
        line_eot = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 9);
        if (pick >= 8)
        begin
            repeat ($urandom_range(1, 12)) text_line.push_back(8'($urandom_range(0, 255)));
            if (!line_eot)
                text_line.push_back(CH_NL);
            return;
        end
        if ($urandom_range(0, 3) == 0)
            text_line.push_back(CH_PERCENT);
        add_blanks($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0, 1, 2, 3, 4:
            begin
                do
                    k = $urandom_range(0, KW_ROUTINE - 1);
                while ((k == KW_DOUBLE) || (k == KW_PRECISION));
                add_folded(kw_spell[k]);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        text_line.push_back(CH_STAR);
                        add_blanks($urandom_range(0, 1));
                        repeat ($urandom_range(1, 2))
                            text_line.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                        add_blanks($urandom_range(0, 2));
                    end
                    1:
                    begin
                        text_line.push_back(CH_STAR);
                        add_blanks($urandom_range(1, 2));
                    end
                    default:
                        add_blanks($urandom_range(0, 2));
                endcase
            end
            5:
            begin
                add_folded(kw_spell[KW_DOUBLE]);
                add_blanks($urandom_range(1, 2));
                add_folded(kw_spell[KW_PRECISION]);
                add_blanks($urandom_range(0, 2));
            end
            default:
                ;
        endcase
        add_folded(kw_spell[$urandom_range(KW_ROUTINE, NKW - 1)]);
        add_blanks($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0:       n = 1;
            1:       n = $urandom_range(NAME_MAX - 2, NAME_MAX + 8);
            default: n = $urandom_range(2, 8);
        endcase
        if ($urandom_range(0, 5) == 0)
            text_line.push_back(8'($urandom_range(8'h80, 8'hFF)));
        else
            add_name_chars(1);
        add_name_chars(n - 1);
        if (!line_eot)
        begin
            case ($urandom_range(0, 2))
                0:
                    text_line.push_back(8'h28);
                1:
                begin
                    text_line.push_back(CH_NUL);
                    repeat ($urandom_range(0, 3)) text_line.push_back(8'($urandom_range(0, 255)));
                end
                default:
                    ;
            endcase
            text_line.push_back(CH_NL);
        end
        if (pick == 7)
            text_line[$urandom_range(0, text_line.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    task automatic test_keywords();
        send_text("%program ab\n");
        send_text("INTEGER*4 FUNCTION Fn_9\n");
        send_text("real* 8 subroutine xy\n");
        send_text("logical*  procedure pq\n");
        send_text("double precision function dp\n");
        send_text(" characterfunction\tcz\n");
        send_text("complex*z function zz\n");
        send_text("%%program ab\n");
        send_text("progra\n");
        send_text("\n");
    endtask

    task automatic test_name_edges();
        send_text("subroutine q\n");
        send_text("functionab(x)\n");
        send_text("program ab");
        send_word(CH_NUL, 1'b0);
        send_text("cd\n");
        send_text("procedure xy");
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        send_text("function ");
        send_word(8'hFF, 1'b0);
        send_text("z1\n");
        send_text("program");
        send_word(8'h0B, 1'b0);
        send_word(8'h0C, 1'b0);
        send_text("name_longer_than_thirty_two_characters_x\n");
    endtask

    task automatic test_backpressure();
        src_idle     = 1'b0;
        sink_stall   = 1'b0;
        hold_request = 1'b1;
        send_text("function ABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789\n");
        src_idle   = 1'b1;
        sink_stall = 1'b1;
    endtask

    task automatic test_random_text();
        while (sent_words < ITEM_TARGET)
        begin
            src_idle   = ($urandom_range(0, 3) != 0);
            sink_stall = ($urandom_range(0, 3) != 0);
            build_line();
            foreach (text_line[i])
                send_word(text_line[i], 1'b0);
            if (line_eot)
                send_word(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                n = HOLD_CYCLES;
            end
            else if (sink_stall && ($urandom_range(0, 2) == 0))
            begin
                n = pick_gap();
            end
            else
            begin
                n = 0;
            end
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        name_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_names.size() == 0)
            begin
                fail_count++;
                $display("%0t: name word expected none actual %h", $time, m_axis_tdata);
            end
            else
            begin
                want = expected_names.pop_front();
                check_field("name_char", 24'(want.name_char), 24'(m_axis_tdata[7:0]));
                check_field("line_number", want.line_number, m_axis_tdata[31:8]);
                check_field("last", 24'(want.last), 24'(m_axis_tlast));
                check_field("truncated", 24'(want.truncated), 24'(m_axis_tuser));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        src_idle      = 1'b1;
        sink_stall    = 1'b1;
        hold_request  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_keywords();
        test_name_edges();
        test_backpressure();
        test_random_text();
        s_axis_tvalid <= 1'b0;
        while (expected_names.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
